@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL that checks itself.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge, masked during reset.
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Plain check that must hold at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/fhlp_pkg.sv @@
// Shared types and constants for the FNV hashed linear probe table.
// No dependencies.
`default_nettype none
package fhlp_pkg;
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned HASH_W      = 64;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned ENTRY_W     = HASH_W + VAL_W;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;

  localparam logic       CMD_INSERT = 1'b0;
  localparam logic       CMD_LOOKUP = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_HIT      = 2'd2;
  localparam logic [1:0] ST_MISS     = 2'd3;

  typedef struct packed {
    logic             command;
    logic [7:0]       key_byte;
    logic             byte_present;
    logic             last_byte;
    logic [VAL_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] found_value;
  } rsp_t;
endpackage
`default_nettype wire

@@ rtl/core/fhlp_ram.sv @@
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module fhlp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/fhlp_hash.sv @@
// Running FNV-1a 64-bit hash over key bytes.
// Depends on fhlp_pkg.
`default_nettype none
module fhlp_hash (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [7:0]                    key_byte,
  input  wire logic                          byte_present,
  input  wire logic                          last_byte,
  output logic      [fhlp_pkg::HASH_W-1:0]   hash_out
);
  import fhlp_pkg::*;

  logic [HASH_W-1:0] acc;
  logic [HASH_W-1:0] mixed;
  logic [HASH_W-1:0] folded;

  // prime = 2^40 + 0x1b3, so the product is a shift plus a short add chain
  always_comb begin
    mixed  = acc ^ {56'd0, key_byte};
    folded = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
           + (mixed << 4) + (mixed << 1) + mixed;
    hash_out = byte_present ? folded : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= FNV_BASIS;
    end else if (step) begin
      acc <= last_byte ? FNV_BASIS : hash_out;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/fnv_hashed_linear_probe_table.sv @@
// Key bytes: one transfer per cycle while idle. Last byte: each probed slot takes a RAM read
// (S_PROBE), then a compare/write (S_CHECK); result registered at the final compare.
// A full wrap probes all TABLE_DEPTH slots; the next key byte can transfer in the same
// cycle that rsp_valid rises.
// Reset clears the used-slot flags at once; hash/value RAM needs no clearing.
`default_nettype none
`include "assert_macros.svh"
module fnv_hashed_linear_probe_table (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire fhlp_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output fhlp_pkg::rsp_t       rsp
);
  import fhlp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PROBE, S_CHECK} state_t;

  state_t             state;
  logic [HASH_W-1:0]  key_hash;
  logic [HASH_W-1:0]  hash_now;
  logic               cmd;
  logic [VAL_W-1:0]   val;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   cnt;
  logic [TABLE_DEPTH-1:0] used;
  logic [ENTRY_W-1:0] rdata;
  logic               take;
  logic               out_free;
  logic               slot_used;
  logic               hit;
  logic               wrapped;
  logic               done;
  logic               rsp_load;
  logic               we;
  rsp_t               result;

  assign req_ready = (state == S_IDLE);
  assign take      = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  fhlp_hash u_hash (
    .clk          (clk),
    .rst          (rst),
    .step         (take),
    .key_byte     (req.key_byte),
    .byte_present (req.byte_present),
    .last_byte    (req.last_byte),
    .hash_out     (hash_now)
  );

  fhlp_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata ({key_hash, val}),
    .raddr (idx),
    .rdata (rdata)
  );

  always_comb begin
    slot_used = used[idx];
    hit       = slot_used && (rdata[ENTRY_W-1:VAL_W] == key_hash);
    wrapped   = (cnt == {IDX_W{1'b1}});
    result    = '{status: ST_MISS, found_value: '0};
    done      = 1'b0;
    if (cmd == CMD_INSERT) begin
      if (!slot_used) begin
        done          = 1'b1;
        result.status = ST_INSERTED;
      end else if (wrapped) begin
        done          = 1'b1;
        result.status = ST_FULL;
      end
    end else begin
      if (hit) begin
        done               = 1'b1;
        result.status      = ST_HIT;
        result.found_value = rdata[VAL_W-1:0];
      end else if (!slot_used || wrapped) begin
        done = 1'b1;
      end
    end
    rsp_load = (state == S_CHECK) && done && out_free;
    // write and result register move together so a stall cannot write twice
    we = rsp_load && (cmd == CMD_INSERT) && !slot_used;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_load || (rsp_valid && !rsp_ready);
      case (state)
        S_IDLE: begin
          if (take && req.last_byte) begin
            key_hash <= hash_now;
            cmd      <= req.command;
            val      <= req.entry_value;
            idx      <= hash_now[IDX_W-1:0];
            cnt      <= '0;
            state    <= S_PROBE;
          end
        end
        S_PROBE: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (done) begin
            if (out_free) begin
              rsp   <= result;
              state <= S_IDLE;
              if (we) begin
                used[idx] <= 1'b1;
              end
            end
          end else begin
            idx   <= idx + 1'b1;
            cnt   <= cnt + 1'b1;
            state <= S_PROBE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_write_free_slot, clk, rst, we |-> !used[idx], "insert over a used slot")
  `ASSERT_IMPL(a_write_sets_used, clk, rst, we |=> used[$past(idx)], "used flag not set")
  `ASSERT_IMPL(a_value_only_hit, clk, rst,
    (rsp_valid && rsp.status != ST_HIT) |-> (rsp.found_value == '0), "value on non-hit")
  `ASSERT_IMPL(a_idle_on_accept, clk, rst, take |-> (state == S_IDLE), "accept while probing")
endmodule
`default_nettype wire

@@ tb/tb_fnv_hashed_linear_probe_table.sv @@
// Testbench for the FNV-1a hashed linear-probe table: streams key bytes, predicts status
// and found value per key, and checks every response in order.
// Depends on fhlp_pkg and fnv_hashed_linear_probe_table.
`default_nettype none
module tb_fnv_hashed_linear_probe_table;
  import fhlp_pkg::*;

  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  class table_scoreboard;
    logic [63:0]      key_hash;
    bit               used [TABLE_DEPTH];
    logic [63:0]      hashes [TABLE_DEPTH];
    logic [VAL_W-1:0] values [TABLE_DEPTH];
    rsp_t             pending_rsp [$];
    int               errors;

    function void clear();
      key_hash = FNV_BASIS;
      foreach (used[i]) used[i] = 1'b0;
      pending_rsp.delete();
      errors = 0;
    endfunction

    // fold one accepted byte; on the last byte run the command on the table copy
    function void note_req(req_t r);
      rsp_t        exp_rsp;
      logic [63:0] h;
      int          start, idx, n;
      if (r.byte_present) key_hash = (key_hash ^ {56'd0, r.key_byte}) * FNV_PRIME;
      if (!r.last_byte) return;
      h = key_hash;
      key_hash = FNV_BASIS;
      start = int'(h % TABLE_DEPTH);
      exp_rsp.found_value = '0;
      if (r.command == CMD_INSERT) begin
        exp_rsp.status = ST_FULL;
        for (n = 0; n < TABLE_DEPTH; n++) begin
          idx = (start + n) % TABLE_DEPTH;
          if (!used[idx]) begin
            used[idx] = 1'b1;
            hashes[idx] = h;
            values[idx] = r.entry_value;
            exp_rsp.status = ST_INSERTED;
            break;
          end
        end
      end else begin
        exp_rsp.status = ST_MISS;
        for (n = 0; n < TABLE_DEPTH; n++) begin
          idx = (start + n) % TABLE_DEPTH;
          if (!used[idx]) break;
          if (hashes[idx] == h) begin
            exp_rsp.status = ST_HIT;
            exp_rsp.found_value = values[idx];
            break;
          end
        end
      end
      pending_rsp.push_back(exp_rsp);
    endfunction

    function void check_rsp(rsp_t got);
      rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response status=%0d value=%h", $time, got.status,
                 got.found_value);
        errors++;
        return;
      end
      exp_rsp = pending_rsp.pop_front();
      if (got.status !== exp_rsp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status, got.status);
        errors++;
      end
      if (got.found_value !== exp_rsp.found_value) begin
        $display("%0t: found_value expected %h actual %h", $time, exp_rsp.found_value,
                 got.found_value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  table_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;
  int cycles = 0;

  always #1 clk = ~clk;

  fnv_hashed_linear_probe_table u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // receiver: random stall, or a long hold when asked
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) sb.check_rsp(rsp);
      rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // valid stays high between back-to-back transfers and drops only for idle gaps
  task automatic send_byte(input req_t r);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_req(r);
  endtask

  // one full key; bytes of zero length give the empty key
  task automatic send_key(input logic cmd, input int len, input logic [VAL_W-1:0] v,
                          input logic [7:0] fill, input bit rand_bytes);
    req_t r;
    int   i;
    r = '0;
    r.command = cmd;
    r.entry_value = v;
    if (len == 0) begin
      r.last_byte = 1'b1;
      r.key_byte = 8'($urandom_range(255));
      send_byte(r);
      return;
    end
    for (i = 0; i < len; i++) begin
      r.key_byte = rand_bytes ? 8'($urandom_range(255)) : fill;
      r.byte_present = 1'b1;
      r.last_byte = (i == len - 1);
      r.command = r.last_byte ? cmd : logic'($urandom_range(1));
      r.entry_value = r.last_byte ? v : $urandom;
      send_byte(r);
      // absent byte mid-key is ignored
      if (!r.last_byte && $urandom_range(9) == 0) begin
        r.byte_present = 1'b0;
        send_byte(r);
        r.byte_present = 1'b1;
      end
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  int         ph, k;
  logic [7:0] kb;

  initial begin
    sb.clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty key, extremes, hit, miss, duplicate
    send_key(CMD_LOOKUP, 0, 32'hffff_ffff, 8'h00, 0);
    send_key(CMD_INSERT, 0, 32'hffff_ffff, 8'h00, 0);
    send_key(CMD_LOOKUP, 0, 32'h0, 8'h00, 0);
    send_key(CMD_INSERT, 1, 32'h0, 8'h00, 0);
    send_key(CMD_INSERT, 1, 32'h1234_5678, 8'hff, 0);
    send_key(CMD_INSERT, 1, 32'hdead_beef, 8'hff, 0);
    send_key(CMD_LOOKUP, 1, 32'h0, 8'hff, 0);
    send_key(CMD_LOOKUP, 1, 32'h0, 8'h00, 0);
    send_key(CMD_LOOKUP, 2, 32'h0, 8'h55, 0);
    send_key(CMD_INSERT, 3, 32'haaaa_5555, 8'haa, 0);
    send_key(CMD_LOOKUP, 3, 32'h5555_aaaa, 8'haa, 0);
    drain();

    // random phases over a growing table; keys are mostly single bytes so hits recur
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 47) : 0;
      recv_stall_pct = (ph == 2) ? 47 : ((ph == 3) ? 16 : 0);
      for (k = 0; k < 60; k++) begin
        kb = 8'($urandom_range(255));
        if ($urandom_range(1)) send_key(CMD_INSERT, 1, $urandom, kb, 0);
        else send_key(CMD_LOOKUP, 1, 0, kb, 0);
        if ($urandom_range(4) == 0) send_key(1'($urandom_range(1)), $urandom_range(0, 5),
                                             $urandom, 0, 1);
      end
      if (ph == 1) begin
        // long receiver hold while keys keep coming
        fork
          begin
            recv_hold = 1'b1;
            repeat (300) @(posedge clk);
            recv_hold = 1'b0;
          end
          for (k = 0; k < 20; k++)
            send_key(1'($urandom_range(1)), 1, $urandom, 8'($urandom), 0);
        join
      end
      drain();
    end

    // fill the table to full, then probe full-wrap lookups and inserts
    send_idle_pct = 0;
    recv_stall_pct = 10;
    while (sb.used.sum() with (int'(item)) < TABLE_DEPTH)
      send_key(CMD_INSERT, $urandom_range(1, 3), $urandom, 0, 1);
    for (k = 0; k < 30; k++)
      send_key(1'($urandom_range(1)), $urandom_range(0, 2), $urandom, 8'($urandom), 1);

    drain();
    repeat (2 * TABLE_DEPTH + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
